[rtl/core/three_wire_serial_master_macros.svh]
// Assertion macros for the three-wire serial master.
// Used by the RTL files that carry assertions; no other dependencies.
`ifndef THREE_WIRE_SERIAL_MASTER_MACROS_SVH
`define THREE_WIRE_SERIAL_MASTER_MACROS_SVH

`ifndef SYNTHESIS
// The expression must never be true outside reset.
`define TWS_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
// The antecedent implies the consequent in the same cycle.
`define TWS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// The antecedent implies the consequent in the next cycle.
`define TWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TWS_ASSERT_NEVER(label, clk, rst_n, expr)
`define TWS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define TWS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/tws_pkg.sv]
// Shared types and constants for the three-wire serial master.
// No dependencies; used by every module of the block.
package tws_pkg;

    // Command codes of an input word; any other code is a plain tick.
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Base values of the command byte and the address mask.
    localparam logic [7:0] CMD_WRITE_BASE = 8'b10000000;
    localparam logic [7:0] CMD_READ_BASE  = 8'b10000001;
    localparam logic [5:0] ADDR_MASK      = 6'h3F;

    // Bit counts that close the send and receive loops.
    localparam logic [4:0] SEND_BITS_READ  = 5'd8;
    localparam logic [4:0] SEND_BITS_WRITE = 5'd16;
    localparam logic [4:0] READ_LAST_BIT   = 5'd7;

    localparam logic [7:0] HALF_PERIOD_RESET = 8'd1;

    // Line phases, one-hot.
    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_SETUP     = 8'b0000_0010,
        PH_CE_ON     = 8'b0000_0100,
        PH_BIT_LOW   = 8'b0000_1000,
        PH_BIT_HIGH  = 8'b0001_0000,
        PH_READ_LOW  = 8'b0010_0000,
        PH_READ_HIGH = 8'b0100_0000,
        PH_TAIL      = 8'b1000_0000
    } tws_phase_t;

    typedef struct packed {
        tws_phase_t  phase;
        logic [4:0]  bit_count;
        logic [15:0] send_shift;
        logic [7:0]  receive_shift;
        logic        is_read;
        logic [7:0]  tick_count;
    } tws_state_t;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] reg_address;
        logic [7:0] write_data;
        logic       io_in;
    } tws_in_t;

    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       io_out;
        logic       io_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } tws_out_t;

endpackage

[rtl/core/tws_step.sv]
// One tick of the serial master: next state and line levels for one word.
// Depends on tws_pkg.
module tws_step (
    input  tws_pkg::tws_state_t state,
    input  tws_pkg::tws_in_t    item,
    input  logic [7:0]          half_period,
    output tws_pkg::tws_state_t state_next,
    output tws_pkg::tws_out_t   result
);
    import tws_pkg::*;

    logic [7:0] period;
    logic [8:0] tick_plus;
    logic       expired;
    logic       done;
    logic [4:0] bit_inc;
    logic [4:0] send_limit;
    logic [5:0] addr;
    tws_state_t nxt;

    // A period of zero behaves as one.
    assign period    = (half_period == 8'd0) ? 8'd1 : half_period;
    assign tick_plus = {1'b0, state.tick_count} + 9'd1;
    assign expired   = tick_plus >= {1'b0, period};
    assign bit_inc   = state.bit_count + 5'd1;
    assign send_limit = state.is_read ? SEND_BITS_READ : SEND_BITS_WRITE;
    assign addr      = item.reg_address & ADDR_MASK;

    // State update: start from idle, otherwise count ticks and advance the phase.
    always_comb
    begin
        nxt  = state;
        done = 1'b0;
        case (state.phase)
            PH_SETUP, PH_CE_ON, PH_BIT_LOW, PH_BIT_HIGH,
            PH_READ_LOW, PH_READ_HIGH, PH_TAIL:
            begin
                if (!expired)
                begin
                    nxt.tick_count = state.tick_count + 8'd1;
                end
                else
                begin
                    nxt.tick_count = 8'd0;
                    case (state.phase)
                        PH_SETUP:
                            nxt.phase = PH_CE_ON;
                        PH_CE_ON:
                        begin
                            nxt.bit_count = 5'd0;
                            nxt.phase     = PH_BIT_LOW;
                        end
                        PH_BIT_LOW:
                            nxt.phase = PH_BIT_HIGH;
                        PH_BIT_HIGH:
                        begin
                            nxt.bit_count = bit_inc;
                            if (bit_inc < send_limit)
                            begin
                                nxt.phase = PH_BIT_LOW;
                            end
                            else if (state.is_read)
                            begin
                                nxt.bit_count = 5'd0;
                                nxt.phase     = PH_READ_LOW;
                            end
                            else
                            begin
                                nxt.phase = PH_TAIL;
                            end
                        end
                        PH_READ_LOW:
                        begin
                            if (item.io_in)
                            begin
                                nxt.receive_shift[state.bit_count[2:0]] = 1'b1;
                            end
                            if (state.bit_count < READ_LAST_BIT)
                            begin
                                nxt.bit_count = bit_inc;
                                nxt.phase     = PH_READ_HIGH;
                            end
                            else
                            begin
                                nxt.phase = PH_TAIL;
                            end
                        end
                        PH_READ_HIGH:
                            nxt.phase = PH_READ_LOW;
                        PH_TAIL:
                        begin
                            nxt.phase = PH_IDLE;
                            done      = 1'b1;
                        end
                        default:
                            nxt.phase = PH_IDLE;
                    endcase
                end
            end
            default:
            begin
                // Idle, or a code that should never appear: only a start request moves on.
                nxt.phase = PH_IDLE;
                case (item.command)
                    CMD_WRITE:
                    begin
                        nxt.is_read       = 1'b0;
                        nxt.send_shift    = {item.write_data,
                                             CMD_WRITE_BASE | {1'b0, addr, 1'b0}};
                        nxt.receive_shift = 8'd0;
                        nxt.bit_count     = 5'd0;
                        nxt.tick_count    = 8'd0;
                        nxt.phase         = PH_SETUP;
                    end
                    CMD_READ:
                    begin
                        nxt.is_read       = 1'b1;
                        nxt.send_shift    = {8'd0, CMD_READ_BASE | {1'b0, addr, 1'b0}};
                        nxt.receive_shift = 8'd0;
                        nxt.bit_count     = 5'd0;
                        nxt.tick_count    = 8'd0;
                        nxt.phase         = PH_SETUP;
                    end
                    default:
                        nxt.phase = PH_IDLE;
                endcase
            end
        endcase
    end

    assign state_next = nxt;

    // Line levels after the update.
    always_comb
    begin
        result           = '0;
        result.busy_res  = (nxt.phase != PH_IDLE);
        result.done_res  = done;
        result.read_data = (done && nxt.is_read) ? nxt.receive_shift : 8'd0;
        case (nxt.phase)
            PH_SETUP:
                result.io_drive = 1'b1;
            PH_CE_ON:
            begin
                result.chip_enable = 1'b1;
                result.io_drive    = 1'b1;
            end
            PH_BIT_LOW, PH_BIT_HIGH:
            begin
                result.chip_enable  = 1'b1;
                result.io_drive     = 1'b1;
                result.serial_clock = (nxt.phase == PH_BIT_HIGH);
                result.io_out       = nxt.send_shift[nxt.bit_count[3:0]];
            end
            PH_READ_LOW, PH_READ_HIGH:
            begin
                result.chip_enable  = 1'b1;
                result.serial_clock = (nxt.phase == PH_READ_HIGH);
            end
            PH_TAIL:
            begin
                result.chip_enable = 1'b1;
                // A write keeps the last data bit on the line.
                result.io_drive    = !nxt.is_read;
                result.io_out      = !nxt.is_read && nxt.send_shift[15];
            end
            default:
                result.busy_res = 1'b0;
        endcase
    end

endmodule

[rtl/core/tws_out_buf.sv]
// Two-entry output stage: result register plus skid register.
// Depends on tws_pkg.
module tws_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tws_pkg::tws_out_t push_word,
    output logic              full,
    output logic              valid,
    input  logic              stall,
    output tws_pkg::tws_out_t word
);
    import tws_pkg::*;

    logic     out_valid_reg, out_valid_next;
    logic     skid_valid_reg, skid_valid_next;
    tws_out_t out_word_reg, out_word_next;
    tws_out_t skid_word_reg, skid_word_next;
    logic     pop;

    assign pop = out_valid_reg && !stall;

    // Fill the result register first; the skid register catches a word while it is held.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_word_next   = out_word_reg;
        skid_word_next  = skid_word_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_word_next   = skid_word_reg;
                skid_valid_next = push;
                skid_word_next  = push_word;
            end
            else
            begin
                out_valid_next = push;
                out_word_next  = push_word;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_word_next  = push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign full  = skid_valid_reg;
    assign valid = out_valid_reg;
    assign word  = out_word_reg;

endmodule

[rtl/core/three_wire_serial_master.sv]
// Three-wire serial master: one word in, one result word out, registered in the output stage.
// Throughput is one word per cycle while in_stall is low; the phase state updates in a single pass per word.
// Two output registers let a word be taken while one result waits downstream.
// Reset (rst_n, asynchronous, active low) returns to idle and sets the half period to 1.
// Depends on tws_pkg, tws_step, tws_out_buf and the assertion macro header.
`include "three_wire_serial_master_macros.svh"

module three_wire_serial_master (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [7:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  tws_pkg::tws_in_t  in_word,
    output logic              out_valid,
    input  logic              out_stall,
    output tws_pkg::tws_out_t out_word
);
    import tws_pkg::*;

    logic       [7:0] half_period_reg;
    tws_state_t state_reg;
    tws_state_t state_next;
    tws_out_t   step_result;
    logic       accept;
    logic       buf_full;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    // Half period register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            half_period_reg <= cfg_data;
        end
    end

    // Transaction state advances once per accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_IDLE, bit_count: 5'd0, send_shift: 16'd0,
                           receive_shift: 8'd0, is_read: 1'b0, tick_count: 8'd0};
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    tws_step u_step (
        .state       (state_reg),
        .item        (in_word),
        .half_period (half_period_reg),
        .state_next  (state_next),
        .result      (step_result)
    );

    tws_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (step_result),
        .full      (buf_full),
        .valid     (out_valid),
        .stall     (out_stall),
        .word      (out_word)
    );

    // The skid register is only ever occupied behind a waiting result.
    `TWS_ASSERT_NEVER(a_skid_behind_out, clk, rst_n, buf_full && !out_valid)
    // A finishing word always reports the block as no longer busy.
    `TWS_ASSERT_IMPLIES(a_done_not_busy, clk, rst_n, accept && step_result.done_res, !step_result.busy_res)
    // Read data appears only on the finishing word.
    `TWS_ASSERT_IMPLIES(a_data_with_done, clk, rst_n, accept && (step_result.read_data != 8'd0), step_result.done_res)
    // The state only moves when a word is taken.
    `TWS_ASSERT_NEXT(a_state_holds, clk, rst_n, !accept, state_reg == $past(state_reg))

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the three-wire serial master.
// Depends on tws_pkg and the three_wire_serial_master top level only.
module tb_top;
    import tws_pkg::*;

    // Command codes that only tick the timebase.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Line patterns for the sampled data input during a transfer.
    localparam int IO_LOW    = 0;
    localparam int IO_HIGH   = 1;
    localparam int IO_RANDOM = 2;

    // Phases of one register access, not counting the start tick.
    localparam int WRITE_PHASES = 35;
    localparam int READ_PHASES  = 34;

    localparam int STUCK_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 4;
    localparam int PHASE_WORDS  = 40;
    localparam int RANDOM_PHASES = 6;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      cfg_write = 1'b0;
    logic [7:0] cfg_data = 8'd0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    tws_in_t   in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    tws_out_t  out_word;

    // Words waiting for the driver and line levels still owed by the block.
    tws_in_t   pending_words[$];
    tws_out_t  expected_lines[$];
    tws_out_t  oldest_line;

    int        idle_pct = 30;
    int        mismatch_count = 0;
    int        stuck_cycles = 0;
    int        phase_words = 0;
    int        active_period = 1;

    // Shadow copy of the block's state and its one register.
    tws_phase_t model_phase = PH_IDLE;
    logic [4:0] model_bits = '0;
    logic [15:0] model_send = '0;
    logic [7:0] model_recv = '0;
    logic       model_read = 1'b0;
    logic [7:0] model_ticks = '0;
    logic [7:0] model_half_period = HALF_PERIOD_RESET;

    three_wire_serial_master uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advances the shadow state by one tick and returns the line levels after it.
    function automatic tws_out_t predict_tick(input tws_in_t w);
        logic [7:0] period;
        logic       finished;
        tws_out_t   lines;
        period = (model_half_period == 8'd0) ? 8'd1 : model_half_period;
        finished = 1'b0;
        lines = '0;
        if (model_phase == PH_IDLE)
        begin
            // A start is only taken while idle, and that tick opens the setup phase.
            if (w.command == CMD_WRITE || w.command == CMD_READ)
            begin
                model_read = (w.command == CMD_READ);
                model_send[7:0] = (model_read ? CMD_READ_BASE : CMD_WRITE_BASE)
                                  | {1'b0, w.reg_address & ADDR_MASK, 1'b0};
                model_send[15:8] = model_read ? 8'd0 : w.write_data;
                model_recv = '0;
                model_bits = '0;
                model_ticks = '0;
                model_phase = PH_SETUP;
            end
        end
        else if ({1'b0, model_ticks} + 9'd1 >= {1'b0, period})
        begin
            model_ticks = '0;
            case (model_phase)
                PH_SETUP:
                    model_phase = PH_CE_ON;
                PH_CE_ON:
                begin
                    model_bits = '0;
                    model_phase = PH_BIT_LOW;
                end
                PH_BIT_LOW:
                    model_phase = PH_BIT_HIGH;
                PH_BIT_HIGH:
                begin
                    model_bits = model_bits + 5'd1;
                    if (model_bits < (model_read ? SEND_BITS_READ : SEND_BITS_WRITE))
                        model_phase = PH_BIT_LOW;
                    else if (model_read)
                    begin
                        model_bits = '0;
                        model_phase = PH_READ_LOW;
                    end
                    else
                        model_phase = PH_TAIL;
                end
                PH_READ_LOW:
                begin
                    // The data line is sampled on the last tick of the low phase.
                    if (w.io_in)
                        model_recv[model_bits[2:0]] = 1'b1;
                    if (model_bits < READ_LAST_BIT)
                    begin
                        model_bits = model_bits + 5'd1;
                        model_phase = PH_READ_HIGH;
                    end
                    else
                        model_phase = PH_TAIL;
                end
                PH_READ_HIGH:
                    model_phase = PH_READ_LOW;
                PH_TAIL:
                begin
                    model_phase = PH_IDLE;
                    finished = 1'b1;
                end
                default:
                    model_phase = PH_IDLE;
            endcase
        end
        else
            model_ticks = model_ticks + 8'd1;

        // Line levels for the phase now in force.
        case (model_phase)
            PH_SETUP:
                lines.io_drive = 1'b1;
            PH_CE_ON:
            begin
                lines.chip_enable = 1'b1;
                lines.io_drive = 1'b1;
            end
            PH_BIT_LOW, PH_BIT_HIGH:
            begin
                lines.chip_enable = 1'b1;
                lines.io_drive = 1'b1;
                lines.serial_clock = (model_phase == PH_BIT_HIGH);
                lines.io_out = model_send[model_bits[3:0]];
            end
            PH_READ_LOW, PH_READ_HIGH:
            begin
                lines.chip_enable = 1'b1;
                lines.serial_clock = (model_phase == PH_READ_HIGH);
            end
            PH_TAIL:
            begin
                lines.chip_enable = 1'b1;
                if (!model_read)
                begin
                    lines.io_drive = 1'b1;
                    lines.io_out = model_send[15];
                end
            end
            default:
                ;
        endcase
        lines.busy_res = (model_phase != PH_IDLE);
        lines.done_res = finished;
        lines.read_data = (finished && model_read) ? model_recv : 8'd0;
        return lines;
    endfunction

    // Driver: presents the next pending word, holding it while stalled.
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                in_word <= pending_words.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < idle_pct);
    end

    // Monitor: predicts on every accepted word, checks every accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_write)
                model_half_period = cfg_data;
            if (in_valid && !in_stall)
                expected_lines.push_back(predict_tick(in_word));
            if (out_valid && !out_stall)
            begin
                if (expected_lines.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word at %0t", $realtime);
                end
                else
                begin
                    oldest_line = expected_lines.pop_front();
                    if (out_word !== oldest_line)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch at %0t: ce/sclk/io/drv/busy/done/rd ",
                                      "expected %b %b %b %b %b %b %h, got %b %b %b %b %b %b %h"},
                                     $realtime, oldest_line.chip_enable,
                                     oldest_line.serial_clock, oldest_line.io_out,
                                     oldest_line.io_drive, oldest_line.busy_res,
                                     oldest_line.done_res, oldest_line.read_data,
                                     out_word.chip_enable, out_word.serial_clock,
                                     out_word.io_out, out_word.io_drive, out_word.busy_res,
                                     out_word.done_res, out_word.read_data);
                    end
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic queue_word(input logic [1:0] cmd, input logic [5:0] addr,
                              input logic [7:0] data, input logic io);
        tws_in_t w;
        w.command = cmd;
        w.reg_address = addr;
        w.write_data = data;
        w.io_in = io;
        pending_words.push_back(w);
        phase_words++;
    endtask

    // Idle ticks; the command is always one that cannot start a transfer.
    task automatic queue_idle(input int count);
        repeat (count)
            queue_word($urandom_range(1) ? CMD_SPARE : CMD_TICK, 6'($urandom),
                       8'($urandom), 1'($urandom));
    endtask

    // One whole register access: the start word and exactly enough ticks to finish.
    // With busy_starts set, the ticks carry random commands, which the block ignores.
    task automatic queue_transfer(input logic [1:0] cmd, input logic [5:0] addr,
                                  input logic [7:0] data, input int io_mode,
                                  input logic busy_starts);
        int  ticks;
        logic io;
        ticks = ((cmd == CMD_READ) ? READ_PHASES : WRITE_PHASES) * active_period;
        queue_word(cmd, addr, data, 1'($urandom));
        repeat (ticks)
        begin
            io = (io_mode == IO_RANDOM) ? 1'($urandom) : (io_mode == IO_HIGH);
            queue_word(busy_starts ? 2'($urandom_range(3)) : CMD_TICK, 6'($urandom),
                       8'($urandom), io);
        end
    endtask

    // Holds off until every word is taken and every result has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_lines.size() != 0);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic set_half_period(input logic [7:0] ticks);
        wait_drained();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= ticks;
        @(posedge clk);
        cfg_write <= 1'b0;
        active_period = (ticks == 8'd0) ? 1 : int'(ticks);
    endtask

    // Stimulus: directed accesses, then random phases under several periods.
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Idle ticks, including the spare command, and both address and data extremes.
        queue_word(CMD_TICK, 6'h3F, 8'hFF, 1'b1);
        queue_word(CMD_SPARE, 6'h3F, 8'hFF, 1'b1);
        queue_word(CMD_SPARE, 6'h00, 8'h00, 1'b0);
        queue_transfer(CMD_WRITE, 6'h00, 8'h00, IO_LOW, 1'b0);
        queue_transfer(CMD_WRITE, 6'h3F, 8'hFF, IO_HIGH, 1'b1);
        queue_transfer(CMD_READ, 6'h00, 8'h00, IO_HIGH, 1'b0);
        queue_transfer(CMD_READ, 6'h3F, 8'hFF, IO_LOW, 1'b1);
        queue_transfer(CMD_READ, 6'($urandom), 8'($urandom), IO_RANDOM, 1'b1);

        // A zero period behaves as one.
        set_half_period(8'd0);
        queue_transfer(CMD_WRITE, 6'($urandom), 8'($urandom), IO_RANDOM, 1'b1);
        queue_transfer(CMD_READ, 6'($urandom), 8'($urandom), IO_RANDOM, 1'b0);

        // Period changed mid phase: shortened below the ticks already spent.
        set_half_period(8'd6);
        queue_word(CMD_READ, 6'h15, 8'h00, 1'b0);
        queue_idle(4);
        set_half_period(8'd1);
        queue_idle(READ_PHASES);
        set_half_period(8'd6);
        queue_word(CMD_WRITE, 6'h2A, 8'hA5, 1'b0);
        queue_idle(8);
        set_half_period(8'd2);
        queue_idle(WRITE_PHASES * 2);

        // The longest period over the whole setup phase of a read, which then
        // finishes at the shortest period.
        set_half_period(8'd255);
        queue_word(CMD_READ, 6'($urandom), 8'($urandom), 1'($urandom));
        queue_idle(256);
        set_half_period(8'd1);
        queue_idle(READ_PHASES);

        // Random phases: mostly whole accesses, some free-running noise.
        for (int phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++)
        begin
            set_half_period((phase_idx % 4 == 3) ? 8'd0 : 8'($urandom_range(1, 4)));
            idle_pct = (phase_idx == 2) ? 0 : 30;
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
            begin
                if ($urandom_range(9) < 8)
                begin
                    queue_idle($urandom_range(3));
                    queue_transfer($urandom_range(1) ? CMD_READ : CMD_WRITE,
                                   6'($urandom), 8'($urandom), IO_RANDOM,
                                   1'($urandom_range(1)));
                end
                else
                begin
                    repeat ($urandom_range(1, 20))
                        queue_word(2'($urandom_range(3)), 6'($urandom), 8'($urandom),
                                   1'($urandom));
                end
                if ($urandom_range(9) == 0)
                    wait_drained();
            end
        end
        idle_pct = 30;

        wait_drained();
        if (mismatch_count == 0 && expected_lines.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
